// ===== rtl/aic_pkg.sv =====
// shared types, constants and tables of the aic onset picker
package aic_pkg;

    localparam int DEF_WINDOW      = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed payload widths
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 21;
    localparam int POS_W    = 6;

    // log result and criterion accumulator widths
    localparam int LN_W     = 32;
    localparam int T_W      = 48;
    localparam int LN_STEPS = 16;

    localparam logic [16:0] LN2_Q16 = 17'd45426;

    // round(2^16 * ln(1 + 2^-i)), entry 0 unused
    localparam logic [15:0] LN_TAB [17] = '{
        16'd0,     16'd26573, 16'd14624, 16'd7719, 16'd3973, 16'd2017,
        16'd1016,  16'd510,   16'd256,   16'd128,  16'd64,   16'd32,
        16'd16,    16'd8,     16'd4,     16'd2,    16'd1
    };

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // operand chosen for the shared log unit
    typedef enum logic [1:0] {
        LN_D1 = 2'd0,
        LN_K  = 2'd1,
        LN_D2 = 2'd2,
        LN_M2 = 2'd3
    } t_ln_sel;

    typedef struct packed {
        logic    start_curve;
        logic    acc;
        logic    mul;
        logic    dif;
        logic    ln_start;
        t_ln_sel ln_sel;
        logic    ln_store;
        logic    term;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic win_go;
        logic inf;
        logic ln_done;
        logic k_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/aic_in_if.sv =====
// sample request channel
interface aic_in_if;
    import aic_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

// ===== rtl/aic_out_if.sv =====
// criterion result request channel
interface aic_out_if;
    import aic_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] aic_value;
    logic                      aic_infinite;
    logic [POS_W-1:0]          split_position;
    logic [POS_W-1:0]          min_position;
    logic                      last_result;

    modport source (output valid, aic_value, aic_infinite, split_position, min_position,
                    last_result, input ready);
    modport sink   (input valid, aic_value, aic_infinite, split_position, min_position,
                    last_result, output ready);
endinterface

// ===== rtl/aic_onset_picker.sv =====
// top level of the akaike criterion onset picker
// Samples are taken one per cycle and written to an internal store of WINDOW
// entries until the request flagged last_sample closes the window (samples
// past WINDOW are dropped). For a window of n >= 2 samples the block then
// sends n-1 result requests, one per split k = 1 .. n-1, carrying
// k*ln(var(x[0..k-1])) + (n-k-1)*ln(var(x[k..n-1])) in q.8; zero variance is
// flagged infinite, and the final request carries the first strict minimum
// position. No samples are taken while a curve is being computed. Timing is
// set by the controller sequence and one shared iterative log unit: a split
// with an infinite value skips the log unit, a finite split needs four log
// evaluations (normalization in 8-bit and 1-bit steps over the difference
// word, then 16 table steps). Results leave through an output register, so
// the next split is computed while the previous result waits to be taken.
module aic_onset_picker #(
    parameter int WINDOW      = aic_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = aic_pkg::DEF_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aic_in_if.sink      i_in,
    aic_out_if.source   o_out
);
    import aic_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     load;

    // sequencer: owns the input handshake and steps each split
    aic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_load     (load),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // store, sums, logs and the result register
    aic_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_load           (load),
        .i_sample         (i_in.sample),
        .i_last           (i_in.last_sample),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_aic_value      (o_out.aic_value),
        .o_aic_infinite   (o_out.aic_infinite),
        .o_split_position (o_out.split_position),
        .o_min_position   (o_out.min_position),
        .o_last_result    (o_out.last_result)
    );

endmodule

// ===== rtl/aic_ln.sv =====
// iterative natural log unit, q.16 result
module aic_ln #(
    parameter int IN_W = 62
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [IN_W-1:0]                   i_v,
    output logic                              o_done,
    output logic signed [aic_pkg::LN_W-1:0]   o_ln
);
    import aic_pkg::*;

    localparam int NORM_W = (IN_W > 32) ? IN_W : 32;
    localparam int SH_W   = $clog2(NORM_W + 1);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_ITER = 4'b0100,
        L_FIN  = 4'b1000
    } t_ln_state;

    t_ln_state          r_state, n_state;
    logic [NORM_W-1:0]  r_v, n_v;
    logic [SH_W-1:0]    r_sh, n_sh;
    logic [31:0]        r_z, n_z;
    logic [4:0]         r_i, n_i;
    logic [16:0]        r_s, n_s;
    logic signed [LN_W-1:0] r_ln, n_ln;
    logic               r_done, n_done;

    logic [31:0]        step;
    logic [SH_W-1:0]    e1;
    logic [LN_W-1:0]    prod;

    assign step = r_z + (r_z >> r_i);
    assign e1   = SH_W'(NORM_W) - r_sh;
    assign prod = LN_W'(e1) * LN_W'(LN2_Q16);

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_sh    = r_sh;
        n_z     = r_z;
        n_i     = r_i;
        n_s     = r_s;
        n_ln    = r_ln;
        n_done  = 1'b0;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_v     = NORM_W'(i_v);
                    n_sh    = '0;
                    n_state = L_NORM;
                end
            end
            L_NORM: begin
                if (r_v[NORM_W-1 -: 8] == 8'd0) begin
                    n_v  = r_v << 8;
                    n_sh = r_sh + SH_W'(8);
                end else if (!r_v[NORM_W-1]) begin
                    n_v  = r_v << 1;
                    n_sh = r_sh + SH_W'(1);
                end else begin
                    n_z     = {1'b0, r_v[NORM_W-1 -: 31]};
                    n_i     = 5'd1;
                    n_s     = '0;
                    n_state = L_ITER;
                end
            end
            L_ITER: begin
                if (step <= 32'h8000_0000) begin
                    n_z = step;
                    n_s = r_s + 17'(LN_TAB[r_i]);
                end
                if (r_i == 5'(LN_STEPS)) begin
                    n_state = L_FIN;
                end else begin
                    n_i = r_i + 5'd1;
                end
            end
            L_FIN: begin
                n_ln    = $signed(prod - LN_W'(r_s));
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_v  <= n_v;
        r_sh <= n_sh;
        r_z  <= n_z;
        r_i  <= n_i;
        r_s  <= n_s;
        r_ln <= n_ln;
    end

    assign o_done = r_done;
    assign o_ln   = r_ln;

endmodule

// ===== rtl/aic_dp.sv =====
// datapath: sample store, segment sums, log terms, minimum tracking, output register
module aic_dp #(
    parameter int WINDOW      = aic_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = aic_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  aic_pkg::t_dp_cmd                     i_cmd,
    output aic_pkg::t_dp_stat                    o_stat,
    input  logic                                 i_load,
    input  logic [aic_pkg::SAMPLE_W-1:0]         i_sample,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [aic_pkg::VALUE_W-1:0]   o_aic_value,
    output logic                                 o_aic_infinite,
    output logic [aic_pkg::POS_W-1:0]            o_split_position,
    output logic [aic_pkg::POS_W-1:0]            o_min_position,
    output logic                                 o_last_result
);
    import aic_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = $clog2(WINDOW);
    localparam int S_W   = SAMPLE_BITS + CNT_W;
    localparam int Q_W   = 2 * SAMPLE_BITS + CNT_W;
    localparam int D_W   = Q_W + CNT_W;

    // input sample, low sample bits as two's complement
    logic [SAMPLE_BITS+SAMPLE_W-1:0] wide;
    logic signed [SAMPLE_BITS-1:0]   x_in;
    logic signed [2*SAMPLE_BITS-1:0] x_in_sq;
    logic signed [2*SAMPLE_BITS-1:0] rd_sq;

    assign wide    = (SAMPLE_BITS + SAMPLE_W)'(i_sample);
    assign x_in    = wide[SAMPLE_BITS-1:0];
    assign x_in_sq = (2*SAMPLE_BITS)'(x_in) * (2*SAMPLE_BITS)'(x_in);

    logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic [IDX_W-1:0]              rd_addr;

    logic [CNT_W-1:0]      r_cnt, r_n, r_k;
    logic [CNT_W-1:0]      cnt_new, m2, c2;
    logic                  store_ok;
    logic signed [S_W-1:0] r_st, r_s1, s2;
    logic [Q_W-1:0]        r_qt, r_q1, q2;
    logic [S_W-1:0]        mag1, mag2;
    logic [D_W-1:0]        mq1, mq2, ss1, ss2;
    logic [D_W-1:0]        r_mq1, r_mq2, r_ss1, r_ss2, r_d1, r_d2;
    logic                  r_inf;
    logic [D_W-1:0]        ln_v;
    logic                  ln_done;
    logic signed [LN_W-1:0] ln_out;
    logic signed [LN_W-1:0] r_ln [4];
    logic signed [T_W-1:0]  r_t, ta, tb, rnd;
    logic signed [CNT_W:0]  c1s, c2s;
    logic signed [VALUE_W-1:0] sat_v, v;
    logic signed [VALUE_W-1:0] r_best_val;
    logic                  r_best_fin;
    logic [POS_W-1:0]      r_best_pos, pos;
    logic                  upd, k_last;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_val;
    logic                      r_out_inf;
    logic [POS_W-1:0]          r_out_pos, r_out_min;
    logic                      r_out_last;

    assign store_ok = r_cnt < CNT_W'(WINDOW);
    assign cnt_new  = store_ok ? r_cnt + CNT_W'(1) : r_cnt;
    assign rd_addr  = IDX_W'(r_k - CNT_W'(1));
    assign rd_sq    = (2*SAMPLE_BITS)'(r_rd) * (2*SAMPLE_BITS)'(r_rd);

    // memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_load && store_ok) begin
            mem[r_cnt[IDX_W-1:0]] <= x_in;
        end
        r_rd <= mem[rd_addr];
    end

    // window fill and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_last ? '0 : cnt_new;
        end
        if (i_load && i_last) begin
            r_n <= cnt_new;
        end
        if (i_load && store_ok) begin
            r_st <= ((r_cnt == '0) ? '0 : r_st) + S_W'(x_in);
            r_qt <= ((r_cnt == '0) ? '0 : r_qt) + Q_W'($unsigned(x_in_sq));
        end
    end

    // segment statistics
    assign s2   = r_st - r_s1;
    assign q2   = r_qt - r_q1;
    assign m2   = r_n - r_k;
    assign c2   = m2 - CNT_W'(1);
    assign mag1 = (r_s1 < 0) ? S_W'(-r_s1) : S_W'(r_s1);
    assign mag2 = (s2 < 0) ? S_W'(-s2) : S_W'(s2);
    assign mq1  = D_W'(r_k) * D_W'(r_q1);
    assign mq2  = D_W'(m2) * D_W'(q2);
    assign ss1  = D_W'(mag1) * D_W'(mag1);
    assign ss2  = D_W'(mag2) * D_W'(mag2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_curve) begin
            r_k  <= CNT_W'(1);
            r_s1 <= '0;
            r_q1 <= '0;
        end else begin
            if (i_cmd.acc) begin
                r_s1 <= r_s1 + S_W'(r_rd);
                r_q1 <= r_q1 + Q_W'($unsigned(rd_sq));
            end
            if (i_cmd.emit) begin
                r_k <= r_k + CNT_W'(1);
            end
        end
        if (i_cmd.mul) begin
            r_mq1 <= mq1;
            r_ss1 <= ss1;
            r_mq2 <= mq2;
            r_ss2 <= ss2;
        end
        if (i_cmd.dif) begin
            r_d1  <= (r_mq1 > r_ss1) ? r_mq1 - r_ss1 : '0;
            r_d2  <= (r_mq2 > r_ss2) ? r_mq2 - r_ss2 : '0;
            r_inf <= !(r_mq1 > r_ss1) || !(r_mq2 > r_ss2);
        end
    end

    // shared log unit operand
    always_comb begin
        case (i_cmd.ln_sel)
            LN_D1:   ln_v = r_d1;
            LN_K:    ln_v = D_W'(r_k);
            LN_D2:   ln_v = r_d2;
            LN_M2:   ln_v = D_W'(m2);
            default: ln_v = r_d1;
        endcase
    end

    aic_ln #(
        .IN_W (D_W)
    ) u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ln_start),
        .i_v     (ln_v),
        .o_done  (ln_done),
        .o_ln    (ln_out)
    );

    // k*ln(var1) + (n-k-1)*ln(var2), var = d/m^2
    assign ta  = T_W'(r_ln[0]) - (T_W'(r_ln[1]) <<< 1);
    assign tb  = T_W'(r_ln[2]) - (T_W'(r_ln[3]) <<< 1);
    assign c1s = {1'b0, r_k};
    assign c2s = {1'b0, c2};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ln_store) begin
            r_ln[i_cmd.ln_sel] <= ln_out;
        end
        if (i_cmd.term) begin
            r_t <= T_W'(c1s) * ta + T_W'(c2s) * tb;
        end
    end

    // round to q.8 with floor, then saturate
    assign rnd = (r_t + T_W'(128)) >>> 8;
    always_comb begin
        if (rnd > T_W'(VALUE_MAX)) begin
            sat_v = VALUE_MAX;
        end else if (rnd < T_W'(VALUE_MIN)) begin
            sat_v = VALUE_MIN;
        end else begin
            sat_v = VALUE_W'(rnd);
        end
    end

    assign v      = r_inf ? VALUE_MAX : sat_v;
    assign pos    = POS_W'(r_k - CNT_W'(1));
    assign k_last = (r_k == r_n - CNT_W'(1));
    assign upd    = !r_inf && (!r_best_fin || (v < r_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_fin  <= 1'b0;
            r_best_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_curve) begin
                r_best_fin <= 1'b0;
                r_best_pos <= '0;
            end else if (i_cmd.emit && upd) begin
                r_best_fin <= 1'b1;
                r_best_pos <= pos;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.emit && upd) begin
            r_best_val <= v;
        end
        if (i_cmd.emit) begin
            r_out_val  <= v;
            r_out_inf  <= r_inf;
            r_out_pos  <= pos;
            r_out_last <= k_last;
            r_out_min  <= k_last ? (upd ? pos : r_best_pos) : '0;
        end
    end

    assign o_stat.win_go   = i_load && i_last && (cnt_new >= CNT_W'(2));
    assign o_stat.inf      = r_inf;
    assign o_stat.ln_done  = ln_done;
    assign o_stat.k_last   = k_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_aic_value      = r_out_val;
    assign o_aic_infinite   = r_out_inf;
    assign o_split_position = r_out_pos;
    assign o_min_position   = r_out_min;
    assign o_last_result    = r_out_last;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending one");
    a_last_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_inf)
        else $error("final split not infinite");
    a_first_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_pos == '0)) |-> r_out_inf)
        else $error("first split not infinite");
    a_min_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_min == '0))
        else $error("min position on a non-final result");
`endif

endmodule

// ===== rtl/aic_ctrl.sv =====
// controller: load phase and per-split sequencing
module aic_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_load,
    input  aic_pkg::t_dp_stat  i_stat,
    output aic_pkg::t_dp_cmd   o_cmd
);
    import aic_pkg::*;

    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_RD   = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_DIF  = 9'b000010000,
        S_LN   = 9'b000100000,
        S_LNW  = 9'b001000000,
        S_TERM = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    t_state  r_state, n_state;
    t_ln_sel r_sel, n_sel;

    assign o_in_ready = (r_state == S_LOAD);
    assign o_load     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.ln_sel = r_sel;
        case (r_state)
            S_LOAD: begin
                if (i_stat.win_go) begin
                    o_cmd.start_curve = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_ACC;
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIF;
            end
            S_DIF: begin
                o_cmd.dif = 1'b1;
                n_sel     = LN_D1;
                n_state   = S_LN;
            end
            S_LN: begin
                if (i_stat.inf) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.ln_start = 1'b1;
                    n_state = S_LNW;
                end
            end
            S_LNW: begin
                if (i_stat.ln_done) begin
                    o_cmd.ln_store = 1'b1;
                    if (r_sel == LN_M2) begin
                        n_state = S_TERM;
                    end else begin
                        n_sel   = t_ln_sel'(r_sel + 2'd1);
                        n_state = S_LN;
                    end
                end
            end
            S_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.k_last ? S_LOAD : S_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_sel   <= LN_D1;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the aic onset picker: sample windows in, criterion curves checked
module testbench;
    import aic_pkg::*;

    logic i_clk;
    logic i_rst_n;

    aic_in_if  smp_ch ();
    aic_out_if crv_ch ();

    aic_onset_picker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_ch),
        .o_out   (crv_ch)
    );

    // criterion point as it should leave the block
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      infinite;
        logic [POS_W-1:0]          split;
        logic [POS_W-1:0]          min_pos;
        logic                      last;
    } t_point;

    localparam int WIN = DEF_WINDOW;
    localparam longint AIC_TOP = 1048575;
    localparam longint AIC_BOT = -1048576;

    t_point                   curve_q[$];
    logic signed [SAMPLE_W-1:0] win_store[WIN];
    int                       win_fill;
    int                       fail_cnt;
    int                       point_cnt;
    int                       window_cnt;
    int                       sample_cnt;
    int                       snd_idle_pct;
    int                       rcv_stall_pct;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // natural log in q.16 via greedy table walk
    function automatic longint ln_fix(longint unsigned v);
        int               e;
        longint unsigned  z;
        longint unsigned  t;
        longint           s;
        e = 63;
        s = 0;
        while (e > 0 && v[e] == 1'b0) e--;
        z = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 1; i <= 16; i++) begin
            t = z + (z >> i);
            if (t <= (64'd1 << 31)) begin
                z = t;
                s += longint'(LN_TAB[i]);
            end
        end
        return longint'(e + 1) * 45426 - s;
    endfunction

    // coefficient times ln of population variance over [lo, hi)
    function automatic longint segment_term(int lo, int hi, longint coef, inout bit inf);
        longint          sum;
        longint unsigned sq;
        longint unsigned mag;
        longint unsigned mq;
        longint unsigned s2;
        longint unsigned d;
        longint          x;
        sum = 0;
        sq  = 0;
        for (int i = lo; i < hi; i++) begin
            x = longint'(win_store[i]);
            sum += x;
            sq  += longint'(x * x);
        end
        mag = (sum < 0) ? -sum : sum;
        mq  = longint'(hi - lo) * sq;
        s2  = mag * mag;
        d   = (mq > s2) ? (mq - s2) : 0;
        if (d == 0) begin
            inf = 1'b1;
            return 0;
        end
        return coef * (ln_fix(d) - 2 * ln_fix(longint'(hi - lo)));
    endfunction

    // q.16 to q.8 with floor rounding and saturation
    function automatic longint round_q8(longint t);
        longint r;
        t += 128;
        r = (t >= 0) ? (t / 256) : -((255 - t) / 256);
        if (r > AIC_TOP) r = AIC_TOP;
        if (r < AIC_BOT) r = AIC_BOT;
        return r;
    endfunction

    // store one accepted sample, and on window end queue the whole curve
    task automatic predict_curve(logic [SAMPLE_W-1:0] smp, logic last);
        int     n;
        bit     inf;
        bit     best_ok;
        longint best_v;
        int     best_k;
        longint v;
        t_point p;
        if (win_fill < WIN) begin
            win_store[win_fill] = smp;
            win_fill++;
        end
        if (!last) return;
        n = win_fill;
        win_fill = 0;
        window_cnt++;
        if (n < 2) return;
        best_ok = 1'b0;
        best_v  = 0;
        best_k  = 0;
        for (int k = 1; k < n; k++) begin
            inf = 1'b0;
            v = segment_term(0, k, k, inf) + segment_term(k, n, n - k - 1, inf);
            v = inf ? AIC_TOP : round_q8(v);
            if (!inf && (!best_ok || v < best_v)) begin
                best_ok = 1'b1;
                best_v  = v;
                best_k  = k - 1;
            end
            p.value    = v[VALUE_W-1:0];
            p.infinite = inf;
            p.split    = POS_W'(k - 1);
            p.last     = (k == n - 1);
            p.min_pos  = p.last ? POS_W'(best_k) : '0;
            curve_q.push_back(p);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_point p;
        if (i_rst_n && crv_ch.valid && crv_ch.ready) begin
            point_cnt++;
            if (curve_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                p = curve_q.pop_front();
                if (crv_ch.aic_value !== p.value)
                    report_mismatch($sformatf("split %0d value %0d want %0d", p.split,
                                              crv_ch.aic_value, p.value));
                if (crv_ch.aic_infinite !== p.infinite)
                    report_mismatch($sformatf("split %0d infinite %b want %b", p.split,
                                              crv_ch.aic_infinite, p.infinite));
                if (crv_ch.split_position !== p.split)
                    report_mismatch($sformatf("split position %0d want %0d",
                                              crv_ch.split_position, p.split));
                if (crv_ch.min_position !== p.min_pos)
                    report_mismatch($sformatf("split %0d min position %0d want %0d", p.split,
                                              crv_ch.min_position, p.min_pos));
                if (crv_ch.last_result !== p.last)
                    report_mismatch($sformatf("split %0d last %b want %b", p.split,
                                              crv_ch.last_result, p.last));
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        crv_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // one sample request, with optional idle cycles in front
    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            smp_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid       = 1'b1;
        smp_ch.sample      = smp;
        smp_ch.last_sample = last;
        do @(posedge i_clk); while (!smp_ch.ready);
        predict_curve(smp, last);
        sample_cnt++;
        @(negedge i_clk);
        smp_ch.valid = 1'b0;
    endtask

    task automatic send_window(logic [SAMPLE_W-1:0] vals[$]);
        foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
    endtask

    // random window; style picks full range, small spread or flat runs
    task automatic send_random_window(int n);
        logic [SAMPLE_W-1:0] vals[$];
        int                  style;
        logic [SAMPLE_W-1:0] base;
        style = $urandom_range(3);
        base  = $urandom;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: vals.push_back($urandom);
                1: vals.push_back(base + $urandom_range(7) - 3);
                2: vals.push_back((i < n / 2) ? base : SAMPLE_W'($urandom));
                default: vals.push_back(($urandom_range(3) == 0) ? base + 1 : base);
            endcase
        end
        send_window(vals);
    endtask

    // hold off until every expected point has left, then let the block settle
    task automatic wait_drained();
        while (curve_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        send_window('{16'h8000, 16'h7fff});
        send_window('{16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
        send_window('{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff});
    endtask

    task automatic test_flat_segments();
        send_window('{16'd5, 16'd5});
        send_window('{16'd3, 16'd3, 16'd3, 16'd9, 16'd9, 16'd9});
        send_window('{16'd1, 16'd2, 16'd3});
    endtask

    task automatic test_short_window();
        send_window('{16'h1234});
        send_window('{16'h0042, 16'hfff0, 16'h0010});
    endtask

    task automatic test_full_store();
        logic [SAMPLE_W-1:0] vals[$];
        for (int i = 0; i < WIN + 6; i++) vals.push_back($urandom);
        send_window(vals);
    endtask

    // sender holds the next window until the previous curve is complete
    task automatic test_drain_pause();
        send_random_window(4);
        wait_drained();
        send_random_window(5);
    endtask

    task automatic test_random(int budget);
        int n;
        int start;
        start = sample_cnt;
        while (sample_cnt - start < budget) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(40, WIN) : $urandom_range(2, 9);
            if ($urandom_range(24) == 0) n = 1;
            send_random_window(n);
        end
    endtask

    initial begin
        fail_cnt      = 0;
        point_cnt     = 0;
        window_cnt    = 0;
        sample_cnt    = 0;
        win_fill      = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        smp_ch.valid       = 1'b0;
        smp_ch.sample      = '0;
        smp_ch.last_sample = 1'b0;
        crv_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_flat_segments();
        test_short_window();
        test_drain_pause();
        test_random(40);
        snd_idle_pct = 67;
        test_full_store();
        test_random(30);
        snd_idle_pct  = 0;
        rcv_stall_pct = 67;
        test_random(35);
        snd_idle_pct  = 27;
        rcv_stall_pct = 27;
        test_random(40);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_drain_pause();
        wait_drained();

        $display("covered %0d windows, %0d samples, %0d curve points checked",
                 window_cnt, sample_cnt, point_cnt);
        if (fail_cnt == 0 && curve_q.size() == 0) begin
            $display("[aic_onset_picker] OK");
        end else begin
            $display("[aic_onset_picker] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("[aic_onset_picker] ERROR");
        $finish;
    end

endmodule
